FILE: design/tlrc_pkg.sv
// tlrc_pkg: shared constants and types of the trace log repeat compressor
// used by the front end, queue, back end and top level; depends on nothing
package tlrc_pkg;

    localparam int MAX_REPORT_WORDS = 1024;

    localparam int FILL_W  = 11;
    localparam int RUN_W   = 16;
    localparam int WORD_W  = 32;
    localparam int LIMIT_W = 11;

    // largest limit a report can take, clipped to what the limit register can hold
    localparam logic [LIMIT_W-1:0] MAX_LIMIT =
        (MAX_REPORT_WORDS > (2 ** LIMIT_W) - 1) ? {LIMIT_W{1'b1}}
                                                 : LIMIT_W'(MAX_REPORT_WORDS);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [FILL_W-1:0]  FILL_MAX    = {FILL_W{1'b1}};
    localparam logic [RUN_W-1:0]   RUN_MAX     = {RUN_W{1'b1}};
    localparam logic [RUN_W-1:0]   RUN_ONE     = 16'd1;
    localparam logic [WORD_W-1:0]  RUN_COUNT_BASE = 32'hffff0000;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // one queued job for the back end: an optional count word, then a value word
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              has_count;
        logic [RUN_W-1:0]  count;
        logic              new_report;
    } t_cmd;

endpackage

FILE: design/tlrc_front.sv
// tlrc_front: accepts trace items, tracks repeat and report state, queues jobs
// depends on tlrc_pkg
module tlrc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [31:0]                  i_trace_value,
    input  logic                         i_q_full,
    input  logic [tlrc_pkg::LIMIT_W-1:0] i_report_limit,
    output logic                         o_accept,
    output logic                         o_push,
    output tlrc_pkg::t_cmd               o_push_cmd
);
    import tlrc_pkg::*;

    logic [WORD_W-1:0] r_prev, n_prev;
    logic              r_loop, n_loop;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic [LIMIT_W-1:0] eff_limit;
    logic [FILL_W:0]    fill_sum;
    logic               at_limit;
    logic               repeat_hit;

    assign o_accept = i_in_valid && !i_q_full;

    always_comb begin
        eff_limit  = (i_report_limit > MAX_LIMIT) ? MAX_LIMIT : i_report_limit;
        at_limit   = r_fill >= FILL_W'(eff_limit);
        repeat_hit = (r_fill != '0) && (r_prev == i_trace_value);
        fill_sum   = {1'b0, r_fill} + (FILL_W + 1)'(1) + (FILL_W + 1)'(r_loop);

        n_prev = r_prev;
        n_loop = r_loop;
        n_run  = r_run;
        n_fill = r_fill;
        o_push = 1'b0;
        o_push_cmd.value      = i_trace_value;
        o_push_cmd.has_count  = 1'b0;
        o_push_cmd.count      = r_run;
        o_push_cmd.new_report = 1'b0;

        if (o_accept) begin
            if (at_limit) begin
                // boundary: value opens a new partial report, loop state kept
                o_push = 1'b1;
                o_push_cmd.new_report = 1'b1;
                n_fill = FILL_W'(1);
                n_prev = i_trace_value;
            end else if (repeat_hit) begin
                if (!r_loop) begin
                    n_loop = 1'b1;
                end else if (r_run < RUN_MAX) begin
                    n_run = r_run + RUN_ONE;
                end
            end else begin
                o_push = 1'b1;
                o_push_cmd.has_count = r_loop;
                n_fill = (fill_sum > {1'b0, FILL_MAX}) ? FILL_MAX : fill_sum[FILL_W-1:0];
                n_prev = i_trace_value;
                n_loop = 1'b0;
                if (r_loop) begin
                    n_run = RUN_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_loop <= 1'b0;
            r_run  <= RUN_ONE;
            r_fill <= '0;
        end else begin
            r_prev <= n_prev;
            r_loop <= n_loop;
            r_run  <= n_run;
            r_fill <= n_fill;
        end
    end

endmodule

FILE: design/tlrc_queue.sv
// tlrc_queue: short job queue between front and back end
// depends on tlrc_pkg
module tlrc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tlrc_pkg::t_cmd i_push_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tlrc_pkg::t_cmd o_head
);
    import tlrc_pkg::*;

    t_cmd           r_slot [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = r_count == QCW'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: design/tlrc_back.sv
// tlrc_back: expands queued jobs into log words through the output register
// depends on tlrc_pkg
module tlrc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tlrc_pkg::t_cmd i_head,
    input  logic           i_out_stall,
    output logic           o_pop,
    output logic           o_out_valid,
    output logic [31:0]    o_log_word,
    output logic           o_is_run_count,
    output logic           o_new_report,
    output logic           o_last
);
    import tlrc_pkg::*;

    logic              r_out_valid;
    logic              r_phase;
    logic [WORD_W-1:0] r_word;
    logic              r_is_count, r_new, r_last;
    logic              advance;
    logic              count_turn;

    assign advance    = !r_out_valid || !i_out_stall;
    assign count_turn = i_head.has_count && !r_phase;
    assign o_pop      = advance && !i_empty && !count_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else if (advance) begin
            r_out_valid <= !i_empty;
            if (!i_empty) begin
                r_phase <= count_turn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_empty) begin
            if (count_turn) begin
                r_word     <= RUN_COUNT_BASE | {{(WORD_W - RUN_W){1'b0}}, i_head.count};
                r_is_count <= 1'b1;
                r_new      <= 1'b0;
                r_last     <= 1'b0;
            end else begin
                r_word     <= i_head.value;
                r_is_count <= 1'b0;
                r_new      <= i_head.new_report;
                r_last     <= 1'b1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_log_word     = r_word;
    assign o_is_run_count = r_is_count;
    assign o_new_report   = r_new;
    assign o_last         = r_last;

endmodule

FILE: design/trace_log_repeat_compressor_unit.sv
// trace_log_repeat_compressor_unit: top level, front end, job queue and back end
// depends on tlrc_pkg, tlrc_front, tlrc_queue, tlrc_back
// latency: the first word of an item passes through the job queue and then the output register
// throughput: one item per cycle while the queue is not full; an item that flushes a run makes
//   two words in turn from the single output register, a four-job queue absorbs that
// reset: synchronous, active low; clears repeat state, report fill and queue,
//   report_limit returns to 1024, and the block takes items as soon as reset is released
module trace_log_repeat_compressor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // trace item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_trace_value,
    // log word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_log_word,
    output logic        o_is_run_count,
    output logic        o_new_report,
    output logic        o_last,
    // report_limit write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import tlrc_pkg::*;

    logic [LIMIT_W-1:0] r_report_limit;

    // front to queue
    logic q_full;
    logic front_accept;
    logic push;
    t_cmd push_cmd;

    // queue to back
    logic q_empty;
    logic pop;
    t_cmd head;

    // config writes land at once, no side effects on the data path
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_report_limit <= i_cfg_data;
        end
    end

    // stall only on a full queue, a registered condition
    assign o_in_stall = q_full;

    // classify each item: suppressed repeat, plain value, flushed run, or report boundary
    tlrc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_trace_value  (i_trace_value),
        .i_q_full       (q_full),
        .i_report_limit (r_report_limit),
        .o_accept       (front_accept),
        .o_push         (push),
        .o_push_cmd     (push_cmd)
    );

    // jobs wait here while the log side stalls
    tlrc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push && front_accept),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_head     (head)
    );

    // one word per cycle, while the log side does not stall, out of the registered output stage
    tlrc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head),
        .i_out_stall    (i_out_stall),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_log_word     (o_log_word),
        .o_is_run_count (o_is_run_count),
        .o_new_report   (o_new_report),
        .o_last         (o_last)
    );

endmodule

FILE: design/tlrc_checker.sv
// tlrc_checker: port-level assertions for the trace log repeat compressor
// bound to trace_log_repeat_compressor_unit; depends on nothing else
module tlrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_log_word,
    input logic        o_is_run_count,
    input logic        o_new_report,
    input logic        o_last
);

    // a held word keeps its value and flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_log_word) &&
        $stable(o_is_run_count) && $stable(o_new_report) && $stable(o_last))
        else $error("output word changed while stalled");

    // a count word carries the count marker and is never final or a boundary
    a_count_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_run_count |->
        o_log_word[31:16] == 16'hffff && !o_last && !o_new_report)
        else $error("malformed run count word");

    // a word that is not a count word always ends its item
    a_value_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_run_count |-> o_last)
        else $error("value word without last");

    // the word after a delivered count word is its value word
    a_count_then_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_is_run_count |=>
        o_out_valid && !o_is_run_count && !o_new_report)
        else $error("count word not followed by its value word");

    // reset empties the output stage
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind trace_log_repeat_compressor_unit tlrc_checker u_tlrc_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for trace_log_repeat_compressor_unit; a directed table, then random
// phases under limit changes, with run-length prediction in the bench; depends on tlrc_pkg and the unit
module tb;

    import tlrc_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 60;
    localparam int SETTLE      = 8;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 46;
    localparam int PREDICTED   = -1;   // table row without a typed expectation

    typedef enum logic { ROW_ITEM, ROW_LIMIT } t_row_kind;

    // one log word as seen on the output ports
    typedef struct packed {
        logic [31:0] word;
        logic        is_count;
        logic        new_rep;
        logic        last;
    } t_log_res;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;
        int unsigned reps;
        int          n_typed;
        t_log_res    t0;
        t_log_res    t1;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic [31:0] trace_value;
    logic        out_stall;
    logic        cfg_valid;
    logic [10:0] cfg_data;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_log_word;
    logic        o_is_run_count;
    logic        o_new_report;
    logic        o_last;
    logic        o_cfg_ready;

    trace_log_repeat_compressor_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_trace_value  (trace_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_log_word     (o_log_word),
        .o_is_run_count (o_is_run_count),
        .o_new_report   (o_new_report),
        .o_last         (o_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // compressor state as the bench sees it
    logic [10:0] limit_reg;
    logic [31:0] last_written;
    logic        loop_armed;
    logic [15:0] repeat_run;
    logic [10:0] words_in_report;

    t_log_res    expected_words[$];
    t_stim_row   directed_rows[$];
    logic [31:0] trace_pool[4];
    logic [31:0] last_sent;

    int  mismatches    = 0;
    int  words_checked = 0;
    int  count_words   = 0;
    int  report_breaks = 0;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  hold_left     = 0;
    int  burst_left    = 0;
    bit  calm          = 1'b0;

    // run-length step: returns how many log words this trace value makes
    function automatic int compress_trace(input logic [31:0] v,
                                          output t_log_res w0, output t_log_res w1);
        int eff_limit;
        int n;
        eff_limit = (int'(limit_reg) > MAX_REPORT_WORDS) ? MAX_REPORT_WORDS
                                                         : int'(limit_reg);
        w0 = '0;
        w1 = '0;
        n  = 0;
        // full report: value opens the next partial report, loop state untouched
        if (int'(words_in_report) >= eff_limit) begin
            words_in_report = 11'd1;
            last_written    = v;
            w0 = {v, 1'b0, 1'b1, 1'b1};
            return 1;
        end
        // repeat of the last written value is swallowed
        if (words_in_report != '0 && last_written == v) begin
            if (!loop_armed)
                loop_armed = 1'b1;
            else if (repeat_run != RUN_MAX)
                repeat_run = repeat_run + 16'd1;
            return 0;
        end
        if (loop_armed) begin
            w0 = {RUN_COUNT_BASE | {16'h0000, repeat_run}, 1'b1, 1'b0, 1'b0};
            n  = 1;
            if (words_in_report != FILL_MAX)
                words_in_report = words_in_report + 11'd1;
            loop_armed = 1'b0;
            repeat_run = RUN_ONE;
        end
        if (n == 0)
            w0 = {v, 1'b0, 1'b0, 1'b1};
        else
            w1 = {v, 1'b0, 1'b0, 1'b1};
        if (words_in_report != FILL_MAX)
            words_in_report = words_in_report + 11'd1;
        last_written = v;
        return n + 1;
    endfunction

    function automatic logic [31:0] pick_trace();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return last_sent;
        else if (roll < 8)
            return trace_pool[$urandom_range(0, 3)];
        else
            return $urandom();
    endfunction

    task automatic add_row(input t_row_kind kind, input logic [31:0] value,
                           input int unsigned reps, input int n_typed,
                           input t_log_res t0, input t_log_res t1);
        t_stim_row r;
        r.kind    = kind;
        r.value   = value;
        r.reps    = reps;
        r.n_typed = n_typed;
        r.t0      = t0;
        r.t1      = t1;
        directed_rows.push_back(r);
    endtask

    // offer one trace item, hold it until accepted, then log what it should produce
    task automatic send_trace(input logic [31:0] v, input int n_typed,
                              input t_log_res t0, input t_log_res t1);
        t_log_res p0;
        t_log_res p1;
        int       n;
        int       gap;
        @(negedge i_clk);
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        trace_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n = compress_trace(v, p0, p1);
        if (n_typed != PREDICTED) begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) expected_words.push_back(p0);
        if (n > 1) expected_words.push_back(p1);
        last_sent  = v;
        items_sent++;
    endtask

    // stop offering and wait until every expected word is out, then let the pipe settle
    task automatic drain_block();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [10:0] lim);
        drain_block();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_reg = lim;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // output check against the oldest expected word
    always @(posedge i_clk) begin
        t_log_res got;
        t_log_res want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && out_stall === 1'b0) begin
            got = {o_log_word, o_is_run_count, o_new_report, o_last};
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected log word, expected none, got %h run %b new %b last %b",
                         $time, got.word, got.is_count, got.new_rep, got.last);
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (want.is_count) count_words++;
                if (want.new_rep) report_breaks++;
                if (got.word !== want.word || got.is_count !== want.is_count ||
                    got.new_rep !== want.new_rep || got.last !== want.last) begin
                    mismatches++;
                    $display("%0t: mismatch, expected %h run %b new %b last %b,",
                             $time, want.word, want.is_count, want.new_rep, want.last,
                             " got %h run %b new %b last %b",
                             got.word, got.is_count, got.new_rep, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d log words outstanding", $time,
                     expected_words.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int          ph;
        int          k;
        logic [10:0] lim;
        logic [31:0] v;
        t_stim_row   r;

        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        trace_value = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        limit_reg       = LIMIT_RESET;
        last_written    = '0;
        loop_armed      = 1'b0;
        repeat_run      = RUN_ONE;
        words_in_report = '0;
        last_sent       = '0;

        // directed rows: kind, value, repeats, typed word count, typed words
        // empty report takes the value even though it equals the reset value
        add_row(ROW_ITEM, 32'h0000_0000, 1, 1, {32'h0000_0000, 3'b001}, '0);
        add_row(ROW_ITEM, 32'h0000_0000, 1, 0, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0000, 2, 0, '0, '0);
        // run flushed as count word then the new value
        add_row(ROW_ITEM, 32'hffff_ffff, 1, 2, {32'hffff_0003, 3'b100},
                {32'hffff_ffff, 3'b001});
        add_row(ROW_ITEM, 32'hffff_ffff, 1, 0, '0, '0);
        add_row(ROW_ITEM, 32'h1234_5678, 1, 2, {32'hffff_0001, 3'b100},
                {32'h1234_5678, 3'b001});
        // tiny limit: every item past the first word opens a report, repeats included
        add_row(ROW_LIMIT, 32'd1, 1, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'ha5a5_a5a5, 2, 1, {32'ha5a5_a5a5, 3'b011}, '0);
        add_row(ROW_LIMIT, 32'd0, 1, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h5a5a_5a5a, 2, 1, {32'h5a5a_5a5a, 3'b011}, '0);
        // limit three: count word overshoot past the limit, then a forced break
        add_row(ROW_LIMIT, 32'd3, 1, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h5a5a_5a5a, 2, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0001, 2, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0002, 2, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0003, 3, PREDICTED, '0, '0);
        // armed loop survives a break forced by lowering the limit
        add_row(ROW_LIMIT, 32'd1, 1, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0003, 1, PREDICTED, '0, '0);
        // oversized limit clips to the largest report
        add_row(ROW_LIMIT, 32'h7ff, 1, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0004, 1, PREDICTED, '0, '0);
        add_row(ROW_ITEM, 32'hdead_beef, 1, PREDICTED, '0, '0);
        // a run of repeats folds into one count word
        add_row(ROW_ITEM, 32'hdead_beef, 6, 0, '0, '0);
        add_row(ROW_ITEM, 32'hcafe_f00d, 1, 2, {32'hffff_0006, 3'b100},
                {32'hcafe_f00d, 3'b001});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.kind == ROW_LIMIT)
                write_limit(r.value[10:0]);
            else
                repeat (r.reps) send_trace(r.value, r.n_typed, r.t0, r.t1);
        end

        // random phases, each under its own limit; every limit change waits for the drain
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       lim = 11'd1;
                1:       lim = 11'd2;
                2:       lim = 11'h7ff;
                3:       lim = 11'd0;
                4:       lim = LIMIT_RESET;
                default: lim = $urandom_range(0, 1) ? 11'($urandom_range(1, 8))
                                                    : 11'($urandom_range(1, 1024));
            endcase
            write_limit(lim);
            calm = (ph == PHASES - 1);
            foreach (trace_pool[j])
                trace_pool[j] = $urandom_range(0, 2) == 0
                              ? 32'($urandom_range(0, 1)) * 32'hffff_ffff
                              : $urandom();
            // hold the receiver while fresh values pile up behind it
            if (ph == 5) hold_requests++;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                v = (ph == 5 && k < 24) ? $urandom() : pick_trace();
                send_trace(v, PREDICTED, '0, '0);
            end
        end

        drain_block();
        $display("%0d trace items sent, %0d log words checked (%0d run counts, %0d breaks)",
                 items_sent, words_checked, count_words, report_breaks);
        $display("limits 0, 1, 2, 3, 1024, 2047 and random, run count words, stalls, long hold");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
